[sv/teq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teq_pkg: shared constants and types of the timed event queue
// Store depth, id range, field widths, operation and status codes and the
// command bundle from the controller to the datapath.
// ----------------------------------------------------------------------------
package teq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_MODULUS  = 1000;

  localparam int TIME_W = 32;
  localparam int ID_W   = 10;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_POP    = 2'd2,
    MODE_COUNT  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic load;
    logic compare;
    logic update;
  } cmd_t;

endpackage

[sv/timed_event_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_event_queue: time-ordered event queue with delete by id
// Usage:
//   Drive in_mode and the operand ports and raise start; the beat is taken
//   at a rising edge where start is high and busy is low. Modes: insert,
//   remove by id, pop earliest, report count.
//   Each beat yields exactly one result, shown on the out_ ports for one
//   cycle while out_valid is high.
//   After the accepting edge, busy stays high through the compare step and
//   then the update of the entry cells, and no new operation is taken
//   meanwhile; out_valid rises from the result register after the update.
//   The next may be accepted in the cycle that shows the previous result.
//   The store holds up to 16 events, earliest first; equal times insert
//   ahead of older entries. Ids count 1, 2, ... and wrap modulo 1000.
//   Reset (rst_n low, synchronous) empties the queue and clears the id
//   counter; entry contents are not cleared, no clearing pass is needed.
//   The receiver cannot stall: results must be taken when out_valid is high.
// ----------------------------------------------------------------------------
module timed_event_queue (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 in_mode,
  input  logic [teq_pkg::TIME_W-1:0] in_event_time,
  input  logic                       in_event_action,
  input  logic [teq_pkg::ID_W-1:0]   in_target_id,
  output logic                       out_valid,
  output logic [1:0]                 out_status,
  output logic [teq_pkg::ID_W-1:0]   out_result_id,
  output logic [teq_pkg::TIME_W-1:0] out_result_time,
  output logic                       out_result_action,
  output logic [teq_pkg::CNT_W-1:0]  out_entry_count
);
  import teq_pkg::*;

  cmd_t cmd;

  teq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  teq_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_mode           (in_mode),
    .in_event_time     (in_event_time),
    .in_event_action   (in_event_action),
    .in_target_id      (in_target_id),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_result_id     (out_result_id),
    .out_result_time   (out_result_time),
    .out_result_action (out_result_action),
    .out_entry_count   (out_entry_count)
  );

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid)
    else $error("result beat missing three cycles after accept");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_entry_count <= CNT_W'(QUEUE_DEPTH)))
    else $error("entry count beyond store depth");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> (out_entry_count == CNT_W'(QUEUE_DEPTH)))
    else $error("full status with store not full");

  a_pop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |->
      (out_result_id == '0 && out_result_time == '0 && !out_result_action))
    else $error("failed operation returned nonzero payload");
`endif

endmodule

[sv/teq_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teq_ctrl: operation sequencer
// Steps each accepted operation through capture, compare and update, and
// raises busy until the update has been applied.
// ----------------------------------------------------------------------------
module teq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  output teq_pkg::cmd_t cmd
);
  import teq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_UPD  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (start) state_nxt = S_CMP;
      S_CMP:  state_nxt = S_UPD;
      S_UPD:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy        = (state_r != S_IDLE);
  assign cmd.load    = (state_r == S_IDLE) && start;
  assign cmd.compare = (state_r == S_CMP);
  assign cmd.update  = (state_r == S_UPD);

endmodule

[sv/teq_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teq_datapath: sorted shift store and result register
// A row of entry cells kept earliest first. Each cell compares its own time
// and id against the operand, then keeps, loads the new event, or takes
// the entry of its left or right neighbor.
// ----------------------------------------------------------------------------
module teq_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  teq_pkg::cmd_t              cmd,
  input  logic [1:0]                 in_mode,
  input  logic [teq_pkg::TIME_W-1:0] in_event_time,
  input  logic                       in_event_action,
  input  logic [teq_pkg::ID_W-1:0]   in_target_id,
  output logic                       out_valid,
  output logic [1:0]                 out_status,
  output logic [teq_pkg::ID_W-1:0]   out_result_id,
  output logic [teq_pkg::TIME_W-1:0] out_result_time,
  output logic                       out_result_action,
  output logic [teq_pkg::CNT_W-1:0]  out_entry_count
);
  import teq_pkg::*;

  typedef enum logic [1:0] {
    SEL_KEEP,
    SEL_NEW,
    SEL_LEFT,
    SEL_RIGHT
  } sel_t;

  // operand beat
  mode_t             mode_r;
  logic [TIME_W-1:0] time_r;
  logic              act_r;
  logic [ID_W-1:0]   tid_r;

  // entry store
  logic [TIME_W-1:0] slot_time_r   [QUEUE_DEPTH];
  logic [ID_W-1:0]   slot_id_r     [QUEUE_DEPTH];
  logic              slot_action_r [QUEUE_DEPTH];

  logic [QUEUE_DEPTH-1:0] lt_r;
  logic [QUEUE_DEPTH-1:0] match_r;
  logic [QUEUE_DEPTH-1:0] hit_pre;
  logic [QUEUE_DEPTH-1:0] valid;
  sel_t                   sel [QUEUE_DEPTH];

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [ID_W-1:0]  idcnt_r, idcnt_nxt, new_id;

  logic              out_valid_r;
  status_t           status_nxt;
  logic [ID_W-1:0]   rid_nxt;
  logic [TIME_W-1:0] rtime_nxt;
  logic              ract_nxt;
  status_t           out_status_r;
  logic [ID_W-1:0]   out_rid_r;
  logic [TIME_W-1:0] out_rtime_r;
  logic              out_ract_r;
  logic [CNT_W-1:0]  out_count_r;

  logic full, empty, found;

  assign full   = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty  = (count_r == '0);
  assign found  = |match_r;
  assign new_id = (idcnt_r == ID_W'(ID_MODULUS - 1)) ? '0 : idcnt_r + ID_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= mode_t'(in_mode);
      time_r <= in_event_time;
      act_r  <= in_event_action;
      tid_r  <= in_target_id;
    end
  end

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic              left_lt;
    logic [TIME_W-1:0] left_time, right_time;
    logic [ID_W-1:0]   left_id, right_id;
    logic              left_act, right_act;

    if (g == 0) begin : g_first
      assign left_lt   = 1'b1;
      assign left_time = '0;
      assign left_id   = '0;
      assign left_act  = 1'b0;
    end else begin : g_inner_l
      assign left_lt   = lt_r[g-1];
      assign left_time = slot_time_r[g-1];
      assign left_id   = slot_id_r[g-1];
      assign left_act  = slot_action_r[g-1];
    end

    if (g == QUEUE_DEPTH - 1) begin : g_last
      assign right_time = '0;
      assign right_id   = '0;
      assign right_act  = 1'b0;
    end else begin : g_inner_r
      assign right_time = slot_time_r[g+1];
      assign right_id   = slot_id_r[g+1];
      assign right_act  = slot_action_r[g+1];
    end

    assign valid[g]   = (CNT_W'(g) < count_r);
    assign hit_pre[g] = |match_r[g:0];

    always_comb begin
      sel[g] = SEL_KEEP;
      unique case (mode_r)
        MODE_INSERT: if (!full && !lt_r[g]) sel[g] = left_lt ? SEL_NEW : SEL_LEFT;
        MODE_REMOVE: if (hit_pre[g]) sel[g] = SEL_RIGHT;
        MODE_POP:    if (!empty) sel[g] = SEL_RIGHT;
        MODE_COUNT:  sel[g] = SEL_KEEP;
        default:     sel[g] = SEL_KEEP;
      endcase
    end

    always_ff @(posedge clk) begin
      if (cmd.compare) begin
        lt_r[g]    <= valid[g] && (slot_time_r[g] < time_r);
        match_r[g] <= valid[g] && (slot_id_r[g] == tid_r);
      end
      if (cmd.update) begin
        unique case (sel[g])
          SEL_NEW: begin
            slot_time_r[g]   <= time_r;
            slot_id_r[g]     <= new_id;
            slot_action_r[g] <= act_r;
          end
          SEL_LEFT: begin
            slot_time_r[g]   <= left_time;
            slot_id_r[g]     <= left_id;
            slot_action_r[g] <= left_act;
          end
          SEL_RIGHT: begin
            slot_time_r[g]   <= right_time;
            slot_id_r[g]     <= right_id;
            slot_action_r[g] <= right_act;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    status_nxt = ST_OK;
    rid_nxt    = '0;
    rtime_nxt  = '0;
    ract_nxt   = 1'b0;
    count_nxt  = count_r;
    idcnt_nxt  = idcnt_r;
    unique case (mode_r)
      MODE_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          rid_nxt   = new_id;
          idcnt_nxt = new_id;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      MODE_REMOVE: begin
        if (found) begin
          rid_nxt   = tid_r;
          count_nxt = count_r - CNT_W'(1);
        end else begin
          status_nxt = ST_NOT_FOUND;
        end
      end
      MODE_POP: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          rid_nxt   = slot_id_r[0];
          rtime_nxt = slot_time_r[0];
          ract_nxt  = slot_action_r[0];
          count_nxt = count_r - CNT_W'(1);
        end
      end
      MODE_COUNT: status_nxt = ST_OK;
      default:    status_nxt = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      idcnt_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.update;
      if (cmd.update) begin
        count_r <= count_nxt;
        idcnt_r <= idcnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_status_r <= status_nxt;
      out_rid_r    <= rid_nxt;
      out_rtime_r  <= rtime_nxt;
      out_ract_r   <= ract_nxt;
      out_count_r  <= count_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_result_id     = out_rid_r;
  assign out_result_time   = out_rtime_r;
  assign out_result_action = out_ract_r;
  assign out_entry_count   = out_count_r;

endmodule

[tb/teq_result_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teq_result_checker: result checker of the timed event queue
// Watches the command and result channels. Every accepted command beat is
// applied to a shadow copy of the sorted event store, and the outcome is
// queued. Every result beat is compared field by field with the oldest
// queued outcome. Reports the failure count and the number of outcomes
// still awaited.
// ----------------------------------------------------------------------------
module teq_result_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  logic [1:0]                 in_mode,
  input  logic [teq_pkg::TIME_W-1:0] in_event_time,
  input  logic                       in_event_action,
  input  logic [teq_pkg::ID_W-1:0]   in_target_id,
  input  logic                       out_valid,
  input  logic [1:0]                 out_status,
  input  logic [teq_pkg::ID_W-1:0]   out_result_id,
  input  logic [teq_pkg::TIME_W-1:0] out_result_time,
  input  logic                       out_result_action,
  input  logic [teq_pkg::CNT_W-1:0]  out_entry_count,
  output int                         fail_count,
  output int                         pending
);
  import teq_pkg::*;

  typedef struct packed {
    status_t           status;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] tm;
    logic              act;
    logic [CNT_W-1:0]  cnt;
  } queue_result_t;

  logic [TIME_W-1:0] ev_time [QUEUE_DEPTH];
  logic [ID_W-1:0]   ev_id   [QUEUE_DEPTH];
  logic              ev_act  [QUEUE_DEPTH];
  logic [CNT_W-1:0]  fill;
  logic [ID_W-1:0]   last_id;
  queue_result_t     awaited_results [$];

  initial begin
    fail_count = 0;
    pending    = 0;
    fill       = '0;
    last_id    = '0;
  end

  task automatic drop_entry(input int pos);
    int k;
    for (k = pos; k + 1 < fill; k++) begin
      ev_time[k] = ev_time[k+1];
      ev_id[k]   = ev_id[k+1];
      ev_act[k]  = ev_act[k+1];
    end
    fill = fill - 1'b1;
  endtask

  task automatic apply_queue_op(input mode_t op, input logic [TIME_W-1:0] t,
                                input logic act, input logic [ID_W-1:0] tid);
    queue_result_t r;
    int pos;
    int k;
    int hit;
    r = '0;
    r.status = ST_OK;
    case (op)
      MODE_INSERT: begin
        if (fill >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          last_id = (last_id == ID_MODULUS - 1) ? '0 : last_id + 1'b1;
          r.id = last_id;
          pos = 0;
          while (pos < fill && ev_time[pos] < t) pos++;
          for (k = fill; k > pos; k--) begin
            ev_time[k] = ev_time[k-1];
            ev_id[k]   = ev_id[k-1];
            ev_act[k]  = ev_act[k-1];
          end
          ev_time[pos] = t;
          ev_id[pos]   = last_id;
          ev_act[pos]  = act;
          fill = fill + 1'b1;
        end
      end
      MODE_REMOVE: begin
        hit = -1;
        for (pos = fill - 1; pos >= 0; pos--) begin
          if (ev_id[pos] == tid) hit = pos;
        end
        if (hit < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.id = tid;
          drop_entry(hit);
        end
      end
      MODE_POP: begin
        if (fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.id  = ev_id[0];
          r.tm  = ev_time[0];
          r.act = ev_act[0];
          drop_entry(0);
        end
      end
      default: begin
      end
    endcase
    r.cnt = fill;
    awaited_results.push_back(r);
  endtask

  task automatic check_result();
    queue_result_t got;
    queue_result_t want;
    got.status = status_t'(out_status);
    got.id     = out_result_id;
    got.tm     = out_result_time;
    got.act    = out_result_action;
    got.cnt    = out_entry_count;
    if (awaited_results.size() == 0) begin
      if (fail_count < 10)
        $display("%0t unexpected result: status %0d id %0d time %0d act %0d count %0d",
                 $realtime, got.status, got.id, got.tm, got.act, got.cnt);
      fail_count++;
    end else begin
      want = awaited_results.pop_front();
      if (got.status !== want.status || got.id !== want.id || got.tm !== want.tm ||
          got.act !== want.act || got.cnt !== want.cnt) begin
        if (fail_count < 10) begin
          $display("%0t result mismatch", $realtime);
          $display("  expected: status %0d id %0d time %0d act %0d count %0d",
                   want.status, want.id, want.tm, want.act, want.cnt);
          $display("  actual:   status %0d id %0d time %0d act %0d count %0d",
                   got.status, got.id, got.tm, got.act, got.cnt);
        end
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      fill    = '0;
      last_id = '0;
      awaited_results.delete();
    end else begin
      if (out_valid) check_result();
      if (start && !busy)
        apply_queue_op(mode_t'(in_mode), in_event_time, in_event_action, in_target_id);
    end
    pending = awaited_results.size();
  end

endmodule

[tb/tb_timed_event_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_timed_event_queue: testbench top of the timed event queue
// Drives a directed opening (empty queue, fill to full, ties, extreme times,
// remove hits and misses) followed by random phases that alternate between
// balanced, filling and draining command mixes and between idling levels of
// the sender. Random removes aim mostly at live ids, taken from the results.
// The checker beside the block predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module tb_timed_event_queue;
  import teq_pkg::*;

  logic              clk             = 1'b0;
  logic              rst_n           = 1'b0;
  logic              start           = 1'b0;
  logic [1:0]        in_mode         = MODE_COUNT;
  logic [TIME_W-1:0] in_event_time   = '0;
  logic              in_event_action = 1'b0;
  logic [ID_W-1:0]   in_target_id    = '0;
  logic              busy;
  logic              out_valid;
  logic [1:0]        out_status;
  logic [ID_W-1:0]   out_result_id;
  logic [TIME_W-1:0] out_result_time;
  logic              out_result_action;
  logic [CNT_W-1:0]  out_entry_count;
  int                fail_count;
  int                pending;

  mode_t             issued_ops [$];
  logic [ID_W-1:0]   live_ids [$];
  int                n_beats     = 0;
  int                n_stored    = 0;
  int                n_full      = 0;
  int                n_empty     = 0;
  int                n_miss      = 0;
  bit                id_wrapped  = 1'b0;

  always #4 clk = ~clk;

  timed_event_queue dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_mode          (in_mode),
    .in_event_time    (in_event_time),
    .in_event_action  (in_event_action),
    .in_target_id     (in_target_id),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_result_id    (out_result_id),
    .out_result_time  (out_result_time),
    .out_result_action(out_result_action),
    .out_entry_count  (out_entry_count)
  );

  teq_result_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_mode          (in_mode),
    .in_event_time    (in_event_time),
    .in_event_action  (in_event_action),
    .in_target_id     (in_target_id),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_result_id    (out_result_id),
    .out_result_time  (out_result_time),
    .out_result_action(out_result_action),
    .out_entry_count  (out_entry_count),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  task automatic forget_id(input logic [ID_W-1:0] id);
    int idx;
    idx = -1;
    foreach (live_ids[i]) if (idx < 0 && live_ids[i] == id) idx = i;
    if (idx >= 0) live_ids.delete(idx);
  endtask

  // track live ids from the result beats to steer removes
  always @(posedge clk) begin
    mode_t op;
    if (rst_n) begin
      if (out_valid && issued_ops.size() > 0) begin
        op = issued_ops.pop_front();
        case (op)
          MODE_INSERT: begin
            if (out_status == ST_OK) begin
              live_ids.push_back(out_result_id);
              n_stored++;
              if (out_result_id == 0) id_wrapped = 1'b1;
            end else begin
              n_full++;
            end
          end
          MODE_REMOVE: begin
            if (out_status == ST_OK) forget_id(out_result_id);
            else n_miss++;
          end
          MODE_POP: begin
            if (out_status == ST_OK) forget_id(out_result_id);
            else n_empty++;
          end
          default: begin
          end
        endcase
      end
      if (start && !busy) issued_ops.push_back(mode_t'(in_mode));
    end
  end

  task automatic send_beat(input mode_t op, input logic [TIME_W-1:0] t,
                           input logic act, input logic [ID_W-1:0] tid);
    in_mode         <= op;
    in_event_time   <= t;
    in_event_action <= act;
    in_target_id    <= tid;
    start           <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    n_beats++;
    @(negedge clk);
  endtask

  task automatic idle_gap(input int pct);
    if ($urandom_range(0, 99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  function automatic logic [TIME_W-1:0] pick_time();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    if (r < 40) return $urandom;
    return $urandom_range(0, 31);
  endfunction

  function automatic mode_t pick_op(input int mix);
    int r;
    int p_ins;
    int p_rem;
    int p_pop;
    r = $urandom_range(0, 99);
    case (mix)
      0: begin p_ins = 50; p_rem = 20; p_pop = 25; end
      1: begin p_ins = 75; p_rem = 10; p_pop = 10; end
      default: begin p_ins = 25; p_rem = 25; p_pop = 45; end
    endcase
    if (r < p_ins) return MODE_INSERT;
    if (r < p_ins + p_rem) return MODE_REMOVE;
    if (r < p_ins + p_rem + p_pop) return MODE_POP;
    return MODE_COUNT;
  endfunction

  function automatic logic [ID_W-1:0] pick_target();
    if (live_ids.size() > 0 && $urandom_range(0, 99) < 80)
      return live_ids[$urandom_range(0, live_ids.size() - 1)];
    return ID_W'($urandom_range(0, ID_MODULUS - 1));
  endfunction

  initial begin
    int idle_pct [3];
    int phase;
    int n_rand;
    int k;
    idle_pct[0] = 0;
    idle_pct[1] = 57;
    idle_pct[2] = 15;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty queue
    send_beat(MODE_POP, '1, 1'b1, '1);
    send_beat(MODE_REMOVE, '0, 1'b0, '0);
    send_beat(MODE_COUNT, '0, 1'b0, '0);
    // fill to full with extremes and ties; ids 1..16
    send_beat(MODE_INSERT, '0, 1'b0, '0);
    send_beat(MODE_INSERT, '1, 1'b1, '0);
    send_beat(MODE_INSERT, 32'd100, 1'b1, '0);
    send_beat(MODE_INSERT, 32'd100, 1'b0, '0);
    for (k = 4; k < QUEUE_DEPTH; k++)
      send_beat(MODE_INSERT, (k * 7919) % 500, k[0], '1);
    send_beat(MODE_INSERT, 32'd50, 1'b1, '0);
    send_beat(MODE_COUNT, '1, 1'b1, '1);
    send_beat(MODE_REMOVE, '0, 1'b0, 10'd5);
    send_beat(MODE_REMOVE, '0, 1'b0, 10'd999);
    send_beat(MODE_POP, '0, 1'b0, '0);
    send_beat(MODE_POP, '0, 1'b0, '0);

    phase  = 0;
    n_rand = 0;
    while (n_rand < 1320) begin
      for (k = 0; k < 120; k++) begin
        send_beat(pick_op((phase + phase / 3) % 3), pick_time(),
                  1'($urandom_range(0, 1)), pick_target());
        idle_gap(idle_pct[phase % 3]);
      end
      n_rand += 120;
      phase++;
    end
    start <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (16) @(negedge clk);

    $display("%0d beats in %0d random phases; %0d events stored, %0d inserts refused as full",
             n_beats, phase, n_stored, n_full);
    $display("%0d pops on empty, %0d remove misses, id counter wrapped: %0d",
             n_empty, n_miss, id_wrapped);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[filelist.f]
sv/teq_pkg.sv
sv/teq_ctrl.sv
sv/teq_datapath.sv
sv/timed_event_queue.sv
tb/teq_result_checker.sv
tb/tb_timed_event_queue.sv
